[rtl/dvst_pkg.sv]
// ----------------------------------------------------------------------------
// Distinct value set table: shared package
// Transaction types, command codes and default sizes used by the set table.
// ----------------------------------------------------------------------------
package dvst_pkg;

   localparam int VALUE_W      = 32;
   localparam int CMD_W        = 2;
   localparam int COUNT_W      = 7;
   localparam int SET_CAPACITY = 64;

   localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic               full_res;
      logic [COUNT_W-1:0] count;
   } rsp_type;

endpackage

[rtl/dvst_store.sv]
// ----------------------------------------------------------------------------
// Distinct value set table: entry store
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
module dvst_store #(
   parameter int DEPTH = dvst_pkg::SET_CAPACITY
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [dvst_pkg::VALUE_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [dvst_pkg::VALUE_W-1:0] rd_data_ff
);

   logic [dvst_pkg::VALUE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

[rtl/distinct_value_set_table_unit.sv]
// ----------------------------------------------------------------------------
// Distinct value set table unit
// Packed store of distinct 32-bit values searched linearly by one comparator.
// ----------------------------------------------------------------------------
// Usage: a request transaction on req_valid/req_ready carries a command (add,
// remove, contains, clear) and a value. Every request gives exactly one
// response transaction on rsp_valid/rsp_ready with a hit flag, a full flag
// and the number of values held afterwards (low seven bits).
// The block works on one request at a time: req_ready is high only while the
// sequencer is idle. A search streams the held entries out of the store one
// per cycle into a single 32-bit equality comparator. A search stops at the
// first match or after the last held entry; a remove that does not hit the
// last entry then moves the last entry into the gap, and clear needs no
// search. The next request can be accepted once the response is raised.
// The response waits in an output register; if the receiver stalls, the next
// request is still accepted and searched, and only its final hand-over waits.
// Reset empties the set and drops any pending response; the entry memory
// needs no clearing pass, as only entries below the count are ever read.
// ----------------------------------------------------------------------------
module distinct_value_set_table_unit #(
   parameter int CAPACITY = dvst_pkg::SET_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dvst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dvst_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EXT_W = (CNT_W > dvst_pkg::COUNT_W) ? CNT_W : dvst_pkg::COUNT_W;

   // Sequencer state codes.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_RDLAST = 3'd2;
   localparam logic [2:0] ST_MOVE   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [CNT_W-1:0]             held_count_ff, held_count_in;
   logic [CNT_W-1:0]             idx_ff, idx_in;
   logic                         cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]             cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]             slot_ff, slot_in;
   logic [dvst_pkg::CMD_W-1:0]   op_cmd_ff, op_cmd_in;
   logic [dvst_pkg::VALUE_W-1:0] op_value_ff, op_value_in;
   logic                         res_hit_ff, res_hit_in;
   logic                         res_full_ff, res_full_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   dvst_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [dvst_pkg::VALUE_W-1:0] wr_data;
   logic                         rd_en;
   logic [IDX_W-1:0]             rd_addr;
   logic [dvst_pkg::VALUE_W-1:0] rd_data;

   logic                         match;
   logic                         scan_end;
   logic [CNT_W-1:0]             last_count;
   logic [EXT_W-1:0]             count_ext;

   dvst_store #(
      .DEPTH (CAPACITY)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // The one shared comparator: the entry read out last cycle against the key.
   assign match      = cmp_vld_ff && (rd_data == op_value_ff);
   assign scan_end   = !cmp_vld_ff && (idx_ff >= held_count_ff);
   assign last_count = held_count_ff - CNT_W'(1);
   assign count_ext  = EXT_W'(held_count_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      held_count_in = held_count_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      slot_in       = slot_ff;
      op_cmd_in     = op_cmd_ff;
      op_value_in   = op_value_ff;
      res_hit_in    = res_hit_ff;
      res_full_in   = res_full_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = held_count_ff[IDX_W-1:0];
      wr_data       = op_value_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_cmd_in   = req_data.cmd;
               op_value_in = $unsigned(req_data.value);
               idx_in      = '0;
               res_hit_in  = 1'b0;
               res_full_in = 1'b0;
               if (req_data.cmd == dvst_pkg::CMD_CLEAR) begin
                  held_count_in = '0;
                  res_hit_in    = 1'b1;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // Issue the next read while comparing the previous one.
            if (idx_ff < held_count_ff) begin
               rd_en      = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = idx_ff[IDX_W-1:0];
               idx_in     = idx_ff + CNT_W'(1);
            end
            if (match) begin
               cmp_vld_in = 1'b0;
               case (op_cmd_ff)
                  dvst_pkg::CMD_REMOVE: begin
                     res_hit_in = 1'b1;
                     slot_in    = cmp_idx_ff;
                     if (CNT_W'(cmp_idx_ff) == last_count) begin
                        held_count_in = last_count;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_RDLAST;
                     end
                  end
                  dvst_pkg::CMD_CONTAINS: begin
                     res_hit_in = 1'b1;
                     state_in   = ST_DONE;
                  end
                  default: begin
                     // Add of a value already held changes nothing.
                     state_in = ST_DONE;
                  end
               endcase
            end else if (scan_end) begin
               if (op_cmd_ff == dvst_pkg::CMD_ADD) begin
                  if (held_count_ff >= CNT_W'(CAPACITY)) begin
                     res_full_in = 1'b1;
                  end else begin
                     wr_en         = 1'b1;
                     held_count_in = held_count_ff + CNT_W'(1);
                     res_hit_in    = 1'b1;
                  end
               end
               state_in = ST_DONE;
            end
         end

         ST_RDLAST: begin
            rd_en    = 1'b1;
            rd_addr  = last_count[IDX_W-1:0];
            state_in = ST_MOVE;
         end

         ST_MOVE: begin
            wr_en         = 1'b1;
            wr_addr       = slot_ff;
            wr_data       = rd_data;
            held_count_in = last_count;
            state_in      = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.hit      = res_hit_ff;
               rsp_data_in.full_res = res_full_ff;
               rsp_data_in.count    = count_ext[dvst_pkg::COUNT_W-1:0];
               state_in             = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_count_ff <= '0;
         cmp_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_count_ff <= held_count_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      slot_ff     <= slot_in;
      op_cmd_ff   <= op_cmd_in;
      op_value_ff <= op_value_in;
      res_hit_ff  <= res_hit_in;
      res_full_ff <= res_full_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The count of held values never exceeds the capacity of the store.
   assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= CNT_W'(CAPACITY))
      else $error("held count exceeds capacity");

   // A new response is only ever raised from the hand-over state.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (!$past(rsp_valid_ff) || $past(rsp_ready)) && !$past(reset))
         |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside hand-over");

   // The store is written only while searching or moving the last entry.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_SCAN || state_ff == ST_MOVE))
      else $error("store written in wrong state");

   // Every insert at the end of a search grows the count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == ST_SCAN) |=> held_count_ff == $past(held_count_ff) + CNT_W'(1))
      else $error("insert without count increment");

endmodule
